### rtl/hogcoh_pkg.sv
// Shared types and constants for the cell orientation histogram block.
package hogcoh_pkg;

   localparam int MAX_BINS_DEF = 16;

   localparam int MAG_W       = 16;
   localparam int ORI_W       = 16;
   localparam int SUM_W       = 34;
   localparam int FRAC_W      = 8;
   localparam int BIN_IDX_W   = 4;
   localparam int BIN_COUNT_W = 5;
   localparam int SHARE_W     = MAG_W + FRAC_W + 1;

   localparam int                  INV_PI_W   = 24;
   localparam logic [INV_PI_W-1:0] INV_PI_Q24 = 24'd5340354;
   localparam int                  POS_SHIFT  = 28;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic                   FULL_TURN_RST = 1'b0;
   localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 5'd9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_TURN = 2'd0,
      CSR_BIN_COUNT = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic        [MAG_W-1:0] magnitude;
      logic signed [ORI_W-1:0] orientation;
      logic                    clear_first;
      logic                    last_pixel;
   } req_word_type;

   typedef struct packed {
      logic [BIN_IDX_W-1:0] bin_index;
      logic [SUM_W-1:0]     bin_value;
      logic                 last_bin;
   } rsp_word_type;

endpackage

### rtl/hog_cell_orientation_histogram.sv
// Cell orientation histogram: per-pixel bilinear binning into a bin memory.
// A pixel keeps busy high from the start word through position calc and the
// lo/hi bin read-modify-writes; with last_pixel, bins 0 to n-1 then strobe out.
// Rate is set by the sequencer sharing one read and one write port of the bank.
// Results cannot be stalled. Reset: bins read as zero, full_turn 0, bin_count 9.
module hog_cell_orientation_histogram #(
   parameter int MAX_BINS = hogcoh_pkg::MAX_BINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hogcoh_pkg::req_word_type            req_word,
   output logic                                rsp_strobe,
   output hogcoh_pkg::rsp_word_type            rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hogcoh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hogcoh_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int NW = $clog2(MAX_BINS + 1);
   localparam int AW = $clog2(MAX_BINS);
   localparam int SW = hogcoh_pkg::SUM_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CALC = 6'b000010,
      ST_WR1  = 6'b000100,
      ST_RD2  = 6'b001000,
      ST_WR2  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type                            state_in, state_ff;
   logic                                 full_turn_ff;
   logic [hogcoh_pkg::BIN_COUNT_W-1:0]   bin_count_ff;
   logic [NW-1:0]                        n_clamp, n_ff;
   logic                                 last_ff;
   logic [AW-1:0]                        k_in, k_ff;
   logic                                 emit_in, emit_ff;
   logic [AW-1:0]                        emit_idx_ff;
   logic                                 emit_last_in, emit_last_ff;
   logic                                 accept;

   logic                                 pos_done;
   logic [AW-1:0]                        lo_bin, hi_bin;
   logic [hogcoh_pkg::SHARE_W-1:0]       lo_share, hi_share, share;

   logic                                 rd_en, wr_en;
   logic [AW-1:0]                        rd_addr, wr_addr;
   logic [SW-1:0]                        rd_data, wr_data;
   logic [SW:0]                          sum;

   assign accept    = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      if (bin_count_ff == '0) begin
         n_clamp = NW'(1);
      end else if (int'(bin_count_ff) > MAX_BINS) begin
         n_clamp = NW'(MAX_BINS);
      end else begin
         n_clamp = NW'(bin_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_turn_ff <= hogcoh_pkg::FULL_TURN_RST;
         bin_count_ff <= hogcoh_pkg::BIN_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (hogcoh_pkg::csr_reg_type'(csr_index))
            hogcoh_pkg::CSR_FULL_TURN: begin
               full_turn_ff <= csr_data[0];
            end
            hogcoh_pkg::CSR_BIN_COUNT: begin
               bin_count_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   hogcoh_pos #(
      .MAX_BINS (MAX_BINS)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .magnitude   (req_word.magnitude),
      .orientation (req_word.orientation),
      .n           (n_clamp),
      .full_turn   (full_turn_ff),
      .done        (pos_done),
      .lo_bin      (lo_bin),
      .hi_bin      (hi_bin),
      .lo_share    (lo_share),
      .hi_share    (hi_share)
   );

   hogcoh_bank #(
      .MAX_BINS (MAX_BINS)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept & req_word.clear_first),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      emit_in      = 1'b0;
      emit_last_in = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = lo_bin;
      wr_en        = 1'b0;
      wr_addr      = lo_bin;
      share        = lo_share;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (pos_done) begin
               rd_en    = 1'b1;
               state_in = ST_WR1;
            end
         end
         ST_WR1: begin
            wr_en    = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            rd_en    = 1'b1;
            rd_addr  = hi_bin;
            state_in = ST_WR2;
         end
         ST_WR2: begin
            wr_en    = 1'b1;
            wr_addr  = hi_bin;
            share    = hi_share;
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            rd_en        = 1'b1;
            rd_addr      = k_ff;
            emit_in      = 1'b1;
            emit_last_in = (NW'(k_ff) == n_ff - 1'b1);
            if (emit_last_in) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // saturate the bin add
   assign sum     = {1'b0, rd_data} + (SW+1)'(share);
   assign wr_data = sum[SW] ? hogcoh_pkg::SUM_MAX : sum[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff    <= n_clamp;
         last_ff <= req_word.last_pixel;
      end
      emit_idx_ff  <= k_ff;
      emit_last_ff <= emit_last_in;
   end

   assign rsp_strobe         = emit_ff;
   assign rsp_word.bin_index = hogcoh_pkg::BIN_IDX_W'(emit_idx_ff);
   assign rsp_word.bin_value = rd_data;
   assign rsp_word.last_bin  = emit_last_ff;

   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> $past(state_ff == ST_EMIT))
      else $error("result word without a preceding emit cycle");

   a_pos_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      pos_done |-> (state_ff == ST_CALC))
      else $error("bin position ready outside the calc state");

   a_last_word_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_ff && emit_last_ff) |-> (state_ff == ST_IDLE))
      else $error("final bin word while the sequencer is still busy");

endmodule

### rtl/hogcoh_pos.sv
// Bin position pipeline: orientation to wrapped bin pair and magnitude shares.
module hogcoh_pos #(
   parameter int  MAX_BINS = hogcoh_pkg::MAX_BINS_DEF,
   localparam int NW       = $clog2(MAX_BINS + 1),
   localparam int AW       = $clog2(MAX_BINS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic        [hogcoh_pkg::MAG_W-1:0]  magnitude,
   input  logic signed [hogcoh_pkg::ORI_W-1:0]  orientation,
   input  logic        [NW-1:0]                 n,
   input  logic                                 full_turn,
   output logic                                 done,
   output logic        [AW-1:0]                 lo_bin,
   output logic        [AW-1:0]                 hi_bin,
   output logic        [hogcoh_pkg::SHARE_W-1:0] lo_share,
   output logic        [hogcoh_pkg::SHARE_W-1:0] hi_share
);

   localparam int P1W = hogcoh_pkg::ORI_W + NW + 1;
   localparam int P2W = P1W + hogcoh_pkg::INV_PI_W + 1;
   localparam int IW  = NW + 4;
   localparam int SW  = hogcoh_pkg::SHARE_W;
   localparam int FW  = hogcoh_pkg::FRAC_W;

   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [P1W-1:0]         prod1_in, prod1_ff;
   logic signed [P2W-1:0]         prod2_in, prod2_ff;
   logic [hogcoh_pkg::MAG_W-1:0]  mag1_ff, mag2_ff;
   logic [NW-1:0]                 n1_ff, n2_ff;
   logic                          ft1_ff, ft2_ff;

   logic signed [P2W-1:0]         pos;
   logic signed [P2W-1:0]         idx_wide;
   logic signed [IW-1:0]          idx;
   logic signed [IW-1:0]          nx, n2x, n3x;
   logic signed [IW-1:0]          cand [6];
   logic signed [IW-1:0]          b1_wide;
   logic [FW-1:0]                 frac;
   logic [AW:0]                   b1_next;
   logic [AW-1:0]                 lo_bin_in, hi_bin_in, lo_bin_ff, hi_bin_ff;
   logic [SW-1:0]                 lo_share_in, hi_share_in, lo_share_ff, hi_share_ff;

   assign prod1_in = $signed(orientation) * $signed({1'b0, n});
   assign prod2_in = prod1_ff * $signed({1'b0, hogcoh_pkg::INV_PI_Q24});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= load;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod1_ff <= prod1_in;
         mag1_ff  <= magnitude;
         n1_ff    <= n;
         ft1_ff   <= full_turn;
      end
      if (v1_ff) begin
         prod2_ff <= prod2_in;
         mag2_ff  <= mag1_ff;
         n2_ff    <= n1_ff;
         ft2_ff   <= ft1_ff;
      end
      if (v2_ff) begin
         lo_bin_ff   <= lo_bin_in;
         hi_bin_ff   <= hi_bin_in;
         lo_share_ff <= lo_share_in;
         hi_share_ff <= hi_share_in;
      end
   end

   always_comb begin
      pos      = ft2_ff ? (prod2_ff >>> (hogcoh_pkg::POS_SHIFT + 1))
                        : (prod2_ff >>> hogcoh_pkg::POS_SHIFT);
      frac     = pos[FW-1:0];
      idx_wide = pos >>> FW;
      idx      = idx_wide[IW-1:0];
      nx       = $signed({4'b0000, n2_ff});
      n2x      = nx <<< 1;
      n3x      = nx + n2x;
      cand[0]  = idx + n3x;
      cand[1]  = idx + n2x;
      cand[2]  = idx + nx;
      cand[3]  = idx;
      cand[4]  = idx - nx;
      cand[5]  = idx - n2x;
      b1_wide  = '0;
      for (int k = 5; k >= 0; k--) begin
         if (cand[k] >= 0 && cand[k] < nx) begin
            b1_wide = cand[k];
         end
      end
      lo_bin_in = b1_wide[AW-1:0];
      b1_next   = {1'b0, lo_bin_in} + 1'b1;
      hi_bin_in = (b1_next == (AW+1)'(n2_ff)) ? '0 : b1_next[AW-1:0];
      hi_share_in = SW'(mag2_ff) * SW'(frac);
      lo_share_in = SW'(mag2_ff) * (SW'(1 << FW) - SW'(frac));
   end

   assign done     = v3_ff;
   assign lo_bin   = lo_bin_ff;
   assign hi_bin   = hi_bin_ff;
   assign lo_share = lo_share_ff;
   assign hi_share = hi_share_ff;

endmodule

### rtl/hogcoh_bank.sv
// Bin sum memory with registered read and per-entry valid bits for fast clear.
module hogcoh_bank #(
   parameter int  MAX_BINS = hogcoh_pkg::MAX_BINS_DEF,
   localparam int AW       = $clog2(MAX_BINS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [hogcoh_pkg::SUM_W-1:0]  rd_data,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [hogcoh_pkg::SUM_W-1:0]  wr_data
);

   logic [hogcoh_pkg::SUM_W-1:0] mem [MAX_BINS];
   logic [MAX_BINS-1:0]          valid_in, valid_ff;
   logic [hogcoh_pkg::SUM_W-1:0] rd_data_ff;
   logic                         rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule
